// ----- rtl/core/affine_2x3_matrix_inverse_top_macros.svh -----
// Assertion macros shared by the affine matrix inverse checker.
`ifndef AFFINE_2X3_MATRIX_INVERSE_TOP_MACROS_SVH
`define AFFINE_2X3_MATRIX_INVERSE_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AFFMI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define AFFMI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/affmi_pkg.sv -----
// Package with widths, types and helper functions of the affine matrix inverse.
`timescale 1ns / 1ps
`default_nettype none
package affmi_pkg;
  localparam int COEF_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int NLANE      = 6;
  localparam int PW         = 2 * COEF_WIDTH;
  localparam int DW         = 2 * COEF_WIDTH;
  localparam int NW_T       = 2 * COEF_WIDTH + FRAC_BITS;
  localparam int NW_C       = COEF_WIDTH + 2 * FRAC_BITS;
  localparam int NW         = (NW_T > NW_C) ? NW_T : NW_C;

  typedef logic signed [COEF_WIDTH-1:0] coef_t;
  typedef logic signed [PW:0]           wide_t;

  typedef struct packed {
    logic [DW-1:0]         rem;
    logic [COEF_WIDTH-1:0] rq;
    logic                  neg;
    logic                  ovf;
  } lane_t;

  typedef struct packed {
    lane_t [NLANE-1:0] lane;
    logic  [DW-1:0]    det;
    logic              det_zero;
  } div_st_t;

  function automatic logic [COEF_WIDTH-1:0] coef_mag(input coef_t x);
    logic [COEF_WIDTH-1:0] u;
    u = x;
    return x[COEF_WIDTH-1] ? (~u + 1'b1) : u;
  endfunction

  function automatic logic [DW-1:0] wide_mag(input wide_t x);
    logic [PW:0] u;
    u = x;
    u = x[PW] ? (~u + 1'b1) : u;
    return u[DW-1:0];
  endfunction
endpackage
`default_nettype wire

// ----- rtl/core/affmi_if.sv -----
// Handshake interfaces for the input and result channels.
`timescale 1ns / 1ps
`default_nettype none
interface affmi_in_if;
  import affmi_pkg::*;
  logic  valid;
  logic  ready;
  coef_t in_a;
  coef_t in_b;
  coef_t in_c;
  coef_t in_d;
  coef_t in_e;
  coef_t in_f;
  modport source(output valid, in_a, in_b, in_c, in_d, in_e, in_f, input ready);
  modport sink(input valid, in_a, in_b, in_c, in_d, in_e, in_f, output ready);
endinterface

interface affmi_out_if;
  import affmi_pkg::*;
  logic  valid;
  logic  ready;
  coef_t inv_a;
  coef_t inv_b;
  coef_t inv_c;
  coef_t inv_d;
  coef_t inv_e;
  coef_t inv_f;
  logic  invertible;
  logic  saturated;
  modport source(output valid, inv_a, inv_b, inv_c, inv_d, inv_e, inv_f, invertible,
                 saturated, input ready);
  modport sink(input valid, inv_a, inv_b, inv_c, inv_d, inv_e, inv_f, invertible,
               saturated, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/affmi_div_cell.sv -----
// One restoring division step for all six lanes, registered.
`timescale 1ns / 1ps
`default_nettype none
module affmi_div_cell (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    en,
  input  wire                    in_v,
  input  affmi_pkg::div_st_t     in_st,
  output logic                   out_v,
  output affmi_pkg::div_st_t     out_st
);
  import affmi_pkg::*;

  div_st_t st_nxt;
  logic    v_r;
  div_st_t st_r;

  always_comb begin
    logic [DW:0] t;
    logic [DW:0] dd;
    logic        ge;
    st_nxt = in_st;
    dd = {1'b0, in_st.det};
    for (int i = 0; i < NLANE; i++) begin
      t  = {in_st.lane[i].rem, in_st.lane[i].rq[COEF_WIDTH-1]};
      ge = (t >= dd);
      st_nxt.lane[i].rem = ge ? DW'(t - dd) : t[DW-1:0];
      st_nxt.lane[i].rq  = {in_st.lane[i].rq[COEF_WIDTH-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign out_v  = v_r;
  assign out_st = st_r;
endmodule
`default_nettype wire

// ----- rtl/core/affmi_front.sv -----
// Front pipeline: products, determinant, numerators and divider set-up.
`timescale 1ns / 1ps
`default_nettype none
module affmi_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 en,
  input  wire                 in_v,
  input  affmi_pkg::coef_t    a,
  input  affmi_pkg::coef_t    b,
  input  affmi_pkg::coef_t    c,
  input  affmi_pkg::coef_t    d,
  input  affmi_pkg::coef_t    e,
  input  affmi_pkg::coef_t    f,
  output logic                out_v,
  output affmi_pkg::div_st_t  out_st
);
  import affmi_pkg::*;

  logic [4:0] v_r;
  coef_t a0_r, b0_r, c0_r, d0_r, e0_r, f0_r;
  logic signed [PW-1:0] p_ae_r, p_bd_r, p_bf_r, p_ec_r, p_dc_r, p_af_r;
  coef_t a1_r, b1_r, d1_r, e1_r;
  wide_t det2_r, n2_r, n5_r;
  coef_t a2_r, b2_r, d2_r, e2_r;
  logic [NLANE-1:0][NW-1:0] num3_r, num3_nxt;
  logic [NLANE-1:0]         neg3_r, neg3_nxt;
  logic [DW-1:0]            det3_r, det3_nxt;
  div_st_t                  st4_r, st4_nxt;

  always_comb begin
    logic det_neg;
    det_neg     = det2_r[PW];
    det3_nxt    = wide_mag(det2_r);
    num3_nxt[0] = NW'(coef_mag(e2_r)) << (2 * FRAC_BITS);
    num3_nxt[1] = NW'(coef_mag(b2_r)) << (2 * FRAC_BITS);
    num3_nxt[2] = NW'(wide_mag(n2_r)) << FRAC_BITS;
    num3_nxt[3] = NW'(coef_mag(d2_r)) << (2 * FRAC_BITS);
    num3_nxt[4] = NW'(coef_mag(a2_r)) << (2 * FRAC_BITS);
    num3_nxt[5] = NW'(wide_mag(n5_r)) << FRAC_BITS;
    neg3_nxt[0] = e2_r[COEF_WIDTH-1] ^ det_neg;
    neg3_nxt[1] = ~b2_r[COEF_WIDTH-1] ^ det_neg;
    neg3_nxt[2] = n2_r[PW] ^ det_neg;
    neg3_nxt[3] = ~d2_r[COEF_WIDTH-1] ^ det_neg;
    neg3_nxt[4] = a2_r[COEF_WIDTH-1] ^ det_neg;
    neg3_nxt[5] = n5_r[PW] ^ det_neg;
  end

  always_comb begin
    logic [NW-1:0] hi;
    logic          ovf;
    st4_nxt.det      = det3_r;
    st4_nxt.det_zero = (det3_r == '0);
    for (int i = 0; i < NLANE; i++) begin
      hi  = num3_r[i] >> COEF_WIDTH;
      ovf = (hi >= NW'(det3_r));
      st4_nxt.lane[i].ovf = ovf;
      st4_nxt.lane[i].neg = neg3_r[i];
      st4_nxt.lane[i].rem = ovf ? '0 : hi[DW-1:0];
      st4_nxt.lane[i].rq  = num3_r[i][COEF_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a0_r   <= a;
      b0_r   <= b;
      c0_r   <= c;
      d0_r   <= d;
      e0_r   <= e;
      f0_r   <= f;
      p_ae_r <= PW'(a0_r) * PW'(e0_r);
      p_bd_r <= PW'(b0_r) * PW'(d0_r);
      p_bf_r <= PW'(b0_r) * PW'(f0_r);
      p_ec_r <= PW'(e0_r) * PW'(c0_r);
      p_dc_r <= PW'(d0_r) * PW'(c0_r);
      p_af_r <= PW'(a0_r) * PW'(f0_r);
      a1_r   <= a0_r;
      b1_r   <= b0_r;
      d1_r   <= d0_r;
      e1_r   <= e0_r;
      det2_r <= {p_ae_r[PW-1], p_ae_r} - {p_bd_r[PW-1], p_bd_r};
      n2_r   <= {p_bf_r[PW-1], p_bf_r} - {p_ec_r[PW-1], p_ec_r};
      n5_r   <= {p_dc_r[PW-1], p_dc_r} - {p_af_r[PW-1], p_af_r};
      a2_r   <= a1_r;
      b2_r   <= b1_r;
      d2_r   <= d1_r;
      e2_r   <= e1_r;
      num3_r <= num3_nxt;
      neg3_r <= neg3_nxt;
      det3_r <= det3_nxt;
      st4_r  <= st4_nxt;
    end
  end

  assign out_v  = v_r[4];
  assign out_st = st4_r;
endmodule
`default_nettype wire

// ----- rtl/core/affmi_back.sv -----
// Back stage: saturation, sign and the result register.
`timescale 1ns / 1ps
`default_nettype none
module affmi_back (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                en,
  input  wire                                in_v,
  input  affmi_pkg::div_st_t                 in_st,
  output logic                               out_v,
  output affmi_pkg::coef_t [affmi_pkg::NLANE-1:0] out_coef,
  output logic                               out_invertible,
  output logic                               out_saturated
);
  import affmi_pkg::*;

  logic                    v_r;
  coef_t [NLANE-1:0]       coef_r, coef_nxt;
  logic                    inv_r, inv_nxt;
  logic                    sat_r, sat_nxt;

  always_comb begin
    logic [COEF_WIDTH-1:0] lim;
    logic [COEF_WIDTH-1:0] val;
    logic                  over;
    sat_nxt = 1'b0;
    inv_nxt = ~in_st.det_zero;
    for (int i = 0; i < NLANE; i++) begin
      lim  = in_st.lane[i].neg ? {1'b1, {(COEF_WIDTH-1){1'b0}}}
                               : {1'b0, {(COEF_WIDTH-1){1'b1}}};
      over = in_st.lane[i].ovf || (in_st.lane[i].rq > lim);
      val  = over ? lim : in_st.lane[i].rq;
      val  = in_st.lane[i].neg ? (~val + 1'b1) : val;
      coef_nxt[i] = in_st.det_zero ? '0 : val;
      sat_nxt = sat_nxt | (over & ~in_st.det_zero);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      coef_r <= coef_nxt;
      inv_r  <= inv_nxt;
      sat_r  <= sat_nxt;
    end
  end

  assign out_v          = v_r;
  assign out_coef       = coef_r;
  assign out_invertible = inv_r;
  assign out_saturated  = sat_r;
endmodule
`default_nettype wire

// ----- rtl/core/affine_2x3_matrix_inverse_top.sv -----
// Top level of the affine 2x3 matrix inverse.
// The block takes one affine matrix [a b c; d e f] per transaction on in_ch and
// returns its inverse, an invertible flag and a saturation flag on out_ch.
// Both channels use valid and ready; a transaction completes when both are high.
// One matrix can be taken in every cycle unless a stalled receiver holds the
// pipeline. A result passes through the front pipeline (input, multiply,
// determinant, magnitude and set-up registers), one divider cell per quotient
// bit, and the result register.
// The whole pipeline advances in a cycle when the result register is empty or
// out_ch.ready is high, so a stalled receiver holds every stage in place and
// in_ch.ready falls in the same cycle.
// A synchronous active-low reset empties the pipeline; in_ch.ready stays low
// until the cycle after reset is released.
`timescale 1ns / 1ps
`default_nettype none
module affine_2x3_matrix_inverse_top (
  input wire          clk,
  input wire          rst_n,
  affmi_in_if.sink    in_ch,
  affmi_out_if.source out_ch
);
  import affmi_pkg::*;

  logic              en;
  logic              run_r;
  logic              front_v;
  div_st_t           front_st;
  logic [COEF_WIDTH:0] cell_v;
  div_st_t [COEF_WIDTH:0] cell_st;
  logic              back_v;
  coef_t [NLANE-1:0] back_coef;
  logic              back_inv;
  logic              back_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else begin
      run_r <= 1'b1;
    end
  end

  assign en          = ~back_v | out_ch.ready;
  assign in_ch.ready = en & run_r;

  affmi_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_v   (in_ch.valid & in_ch.ready),
    .a      (in_ch.in_a),
    .b      (in_ch.in_b),
    .c      (in_ch.in_c),
    .d      (in_ch.in_d),
    .e      (in_ch.in_e),
    .f      (in_ch.in_f),
    .out_v  (front_v),
    .out_st (front_st)
  );

  assign cell_v[0]  = front_v;
  assign cell_st[0] = front_st;

  for (genvar g = 0; g < COEF_WIDTH; g++) begin : g_cell
    affmi_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .in_v   (cell_v[g]),
      .in_st  (cell_st[g]),
      .out_v  (cell_v[g+1]),
      .out_st (cell_st[g+1])
    );
  end

  affmi_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .in_v           (cell_v[COEF_WIDTH]),
    .in_st          (cell_st[COEF_WIDTH]),
    .out_v          (back_v),
    .out_coef       (back_coef),
    .out_invertible (back_inv),
    .out_saturated  (back_sat)
  );

  assign out_ch.valid      = back_v;
  assign out_ch.inv_a      = back_coef[0];
  assign out_ch.inv_b      = back_coef[1];
  assign out_ch.inv_c      = back_coef[2];
  assign out_ch.inv_d      = back_coef[3];
  assign out_ch.inv_e      = back_coef[4];
  assign out_ch.inv_f      = back_coef[5];
  assign out_ch.invertible = back_inv;
  assign out_ch.saturated  = back_sat;
endmodule
`default_nettype wire

// ----- rtl/core/affmi_checker.sv -----
// Port-level checker for the affine matrix inverse, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "affine_2x3_matrix_inverse_top_macros.svh"
module affmi_checker (
  input wire                   clk,
  input wire                   rst_n,
  input wire                   out_valid,
  input wire                   out_ready,
  input wire [affmi_pkg::COEF_WIDTH-1:0] inv_a,
  input wire [affmi_pkg::COEF_WIDTH-1:0] inv_b,
  input wire [affmi_pkg::COEF_WIDTH-1:0] inv_c,
  input wire [affmi_pkg::COEF_WIDTH-1:0] inv_d,
  input wire [affmi_pkg::COEF_WIDTH-1:0] inv_e,
  input wire [affmi_pkg::COEF_WIDTH-1:0] inv_f,
  input wire                   invertible,
  input wire                   saturated
);
  import affmi_pkg::*;

  `AFFMI_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `AFFMI_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(inv_a) && $stable(inv_c) && $stable(invertible) && $stable(saturated))
  `AFFMI_ASSERT_IMP(a_singular_zero, clk, rst_n, out_valid && !invertible, inv_a == '0 && inv_b == '0 && inv_c == '0 && inv_d == '0 && inv_e == '0 && inv_f == '0 && !saturated)
  `AFFMI_ASSERT_IMP(a_sat_inv, clk, rst_n, out_valid && saturated, invertible)
endmodule

bind affine_2x3_matrix_inverse_top affmi_checker u_affmi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .inv_a      (out_ch.inv_a),
  .inv_b      (out_ch.inv_b),
  .inv_c      (out_ch.inv_c),
  .inv_d      (out_ch.inv_d),
  .inv_e      (out_ch.inv_e),
  .inv_f      (out_ch.inv_f),
  .invertible (out_ch.invertible),
  .saturated  (out_ch.saturated)
);
`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for the affine 2x3 matrix inverse with a scoreboard class.
`timescale 1ns / 1ps
module testbench;
  import affmi_pkg::*;

  typedef struct {
    coef_t a, b, c, d, e, f;
  } matrix_t;

  typedef struct {
    coef_t a, b, c, d, e, f;
    logic  invertible;
    logic  saturated;
  } inverse_t;

  class inverse_scoreboard;
    inverse_t pending[$];
    int       errors;
    int       checked;
    int       singular_seen;
    int       clamped_seen;

    // Truncated quotient of num * 2^shift by den, clamped to the coefficient range.
    function automatic coef_t scaled_div(logic signed [127:0] num, int shift,
                                         logic signed [127:0] den, ref logic sat);
      logic                neg;
      logic [127:0]        nm, dm, q, lim;
      neg = (num < 0) != (den < 0);
      nm  = (num < 0) ? -num : num;
      dm  = (den < 0) ? -den : den;
      nm  = nm << shift;
      q   = nm / dm;
      lim = neg ? (128'd1 << (COEF_WIDTH - 1)) : ((128'd1 << (COEF_WIDTH - 1)) - 1);
      if (q > lim) begin
        q   = lim;
        sat = 1'b1;
      end
      q = neg ? -q : q;
      return q[COEF_WIDTH-1:0];
    endfunction

    function void note_matrix(matrix_t m);
      logic signed [127:0] a, b, c, d, e, f, det;
      inverse_t r;
      logic sat;
      a = m.a; b = m.b; c = m.c; d = m.d; e = m.e; f = m.f;
      det = a * e - b * d;
      sat = 1'b0;
      r = '{default: '0};
      if (det != 0) begin
        r.a = scaled_div(e, 2 * FRAC_BITS, det, sat);
        r.b = scaled_div(-b, 2 * FRAC_BITS, det, sat);
        r.c = scaled_div(b * f - e * c, FRAC_BITS, det, sat);
        r.d = scaled_div(-d, 2 * FRAC_BITS, det, sat);
        r.e = scaled_div(a, 2 * FRAC_BITS, det, sat);
        r.f = scaled_div(d * c - a * f, FRAC_BITS, det, sat);
        r.invertible = 1'b1;
        r.saturated  = sat;
      end
      pending.push_back(r);
    endfunction

    function void check_inverse(inverse_t got);
      inverse_t x;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual inv_a=%h", $time, got.a);
        errors++;
        return;
      end
      x = pending.pop_front();
      checked++;
      if (!got.invertible) singular_seen++;
      if (got.saturated) clamped_seen++;
      if (got.a !== x.a) report("inv_a", x.a, got.a);
      if (got.b !== x.b) report("inv_b", x.b, got.b);
      if (got.c !== x.c) report("inv_c", x.c, got.c);
      if (got.d !== x.d) report("inv_d", x.d, got.d);
      if (got.e !== x.e) report("inv_e", x.e, got.e);
      if (got.f !== x.f) report("inv_f", x.f, got.f);
      if (got.invertible !== x.invertible) report("invertible", x.invertible, got.invertible);
      if (got.saturated !== x.saturated) report("saturated", x.saturated, got.saturated);
    endfunction

    function void report(string name, logic [31:0] exp_v, logic [31:0] act_v);
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      errors++;
    endfunction
  endclass

  localparam int LATENCY = COEF_WIDTH + 5;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1880;

  logic clk;
  logic rst_n;
  affmi_in_if  in_ch();
  affmi_out_if out_ch();
  inverse_scoreboard board;
  matrix_t directed_set[$];
  int idle_cycles;
  bit stimulus_done;
  int sent;

  affine_2x3_matrix_inverse_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic coef_t random_coef();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000 + $urandom_range(0, 2);
      1: return 32'sh7fff_ffff - $urandom_range(0, 2);
      2: return $urandom_range(0, 4) - 2;
      3: return $signed($urandom_range(0, 32'h3_ffff)) - 32'sh2_0000;
      4: return $signed($urandom_range(0, 32'h100)) << $urandom_range(0, 23);
      default: return $urandom();
    endcase
  endfunction

  function automatic matrix_t random_matrix();
    matrix_t m;
    m.a = random_coef(); m.b = random_coef(); m.c = random_coef();
    m.d = random_coef(); m.e = random_coef(); m.f = random_coef();
    case ($urandom_range(0, 9))
      0: begin
        m.a = m.d; m.b = m.e;
      end
      1: begin
        m.b = '0; m.d = '0;
      end
      default: ;
    endcase
    return m;
  endfunction

  task automatic send_matrix(matrix_t m);
    int g;
    g = gap_length();
    if (g != 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_a <= m.a; in_ch.in_b <= m.b; in_ch.in_c <= m.c;
    in_ch.in_d <= m.d; in_ch.in_e <= m.e; in_ch.in_f <= m.f;
    do @(posedge clk); while (!in_ch.ready);
    board.note_matrix(m);
    sent++;
    if (sent == RANDOM_ITEMS + directed_set.size())
      in_ch.valid <= 1'b0;
  endtask

  function automatic matrix_t mk(coef_t a, coef_t b, coef_t c, coef_t d, coef_t e, coef_t f);
    matrix_t m;
    m.a = a; m.b = b; m.c = c; m.d = d; m.e = e; m.f = f;
    return m;
  endfunction

  initial begin
    coef_t one, mx, mn;
    board = new();
    one = 32'sh1_0000; mx = 32'sh7fff_ffff; mn = 32'sh8000_0000;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    {in_ch.in_a, in_ch.in_b, in_ch.in_c, in_ch.in_d, in_ch.in_e, in_ch.in_f} = '0;
    out_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    directed_set.push_back(mk(one, 0, 0, 0, one, 0));
    directed_set.push_back(mk(2 * one, 0, 5 * one, 0, 4 * one, -3 * one));
    directed_set.push_back(mk(0, 0, 0, 0, 0, 0));
    directed_set.push_back(mk(one, 2 * one, 7, 2 * one, 4 * one, 9));
    directed_set.push_back(mk(1, 0, mx, 0, 1, mn));
    directed_set.push_back(mk(mx, mn, mx, mn, mx, mn));
    directed_set.push_back(mk(mn, mn, mn, mn, mn, mn));
    directed_set.push_back(mk(mn, 0, 0, 0, mn, 0));
    directed_set.push_back(mk(mx, 0, mn, 0, mx, mx));
    directed_set.push_back(mk(0, mn, one, mn, 0, -one));
    directed_set.push_back(mk(0, one, 3, -one, 0, -5));
    directed_set.push_back(mk(-one, 1, -1, 1, -one, 1));
    directed_set.push_back(mk(1, 1, 1, 0, 1, 1));
    directed_set.push_back(mk(-1, -1, -1, -1, -1, -1));
    directed_set.push_back(mk(32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555,
                              32'shaaaa_aaaa, 32'sh5555_5555, 32'shaaaa_aaaa));
    directed_set.push_back(mk(3 * one, one, -2 * one, one, 3 * one, 7 * one));
    foreach (directed_set[i]) send_matrix(directed_set[i]);
    for (int i = 0; i < RANDOM_ITEMS; i++) send_matrix(random_matrix());
    stimulus_done = 1'b1;
  end

  // Receiver: random back-pressure with occasional long stalls.
  initial begin
    int g;
    @(posedge rst_n);
    forever begin
      g = gap_length();
      if (g != 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    inverse_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.a = out_ch.inv_a; got.b = out_ch.inv_b; got.c = out_ch.inv_c;
      got.d = out_ch.inv_d; got.e = out_ch.inv_e; got.f = out_ch.inv_f;
      got.invertible = out_ch.invertible;
      got.saturated  = out_ch.saturated;
      board.check_inverse(got);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout after %0d cycles without a transaction.", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
      if (stimulus_done && board.pending.size() == 0) begin
        repeat (2 * LATENCY) @(posedge clk);
        $display("Checked %0d inverses: %0d singular, %0d with clamped quotients.",
                 board.checked, board.singular_seen, board.clamped_seen);
        if (board.errors == 0 && board.pending.size() == 0)
          $display("ALL CHECKS PASSED");
        else
          $display("CHECKS FAILED");
        $finish;
      end
    end
  end
endmodule
